>>> hw/rtl/tlvd_pkg.sv
// tlvd_pkg: shared codes and types of the tlv response deframer
// no dependencies; used by the parser, the top level and the checker

package tlvd_pkg;

  localparam logic [2:0] KIND_TAG    = 3'd0;
  localparam logic [2:0] KIND_LEN_HI = 3'd1;
  localparam logic [2:0] KIND_LEN_LO = 3'd2;
  localparam logic [2:0] KIND_VALUE  = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SHORT  = 2'd1;
  localparam logic [1:0] ERR_HEADER = 2'd2;
  localparam logic [1:0] ERR_BOUNDS = 2'd3;

  localparam logic FMT_TLV  = 1'b0;
  localparam logic FMT_TLLV = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } step_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  content_byte;
    logic [7:0]  record_tag;
    logic [15:0] record_length;
    logic        record_end;
    logic [15:0] status_word;
    logic [1:0]  error_code;
    logic        frame_end;
  } result_t;

endpackage

>>> hw/rtl/tlvd_if.sv
// tlvd channel interfaces: frame byte input, result output, format write
// depends on nothing

interface tlvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, frame_byte, frame_last, input ready);
  modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

interface tlvd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_kind;
  logic [7:0]  content_byte;
  logic [7:0]  record_tag;
  logic [15:0] record_length;
  logic        record_end;
  logic [15:0] status_word;
  logic [1:0]  error_code;
  logic        frame_end;

  modport source (output valid, byte_kind, content_byte, record_tag, record_length,
                  record_end, status_word, error_code, frame_end, input ready);
  modport sink   (input valid, byte_kind, content_byte, record_tag, record_length,
                  record_end, status_word, error_code, frame_end, output ready);
endinterface

interface tlvd_cfg_if;
  logic valid;
  logic ready;
  logic record_format;

  modport source (output valid, record_format, input ready);
  modport sink   (input valid, record_format, output ready);
endinterface

>>> hw/rtl/tlv_response_deframer.sv
// tlv_response_deframer: top level, input register, format register, result register
// depends on tlvd_pkg, tlvd_if and tlvd_parser
// a result passes from the input register through the parser into the result register
// throughput: one byte per cycle, set by the single parse step between the input and
// result registers; back-pressure holds one byte in the input register
// reset: async active low, clears the hold, the parser phase and the format (tlv)

module tlv_response_deframer (
  input  logic   clk_i,
  input  logic   rst_ni,
  tlvd_in_if.sink    in_chan_i,
  tlvd_cfg_if.sink   cfg_i,
  tlvd_out_if.source out_chan_o
);

  // format register, sampled by the parser on each tag byte
  logic fmt_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= tlvd_pkg::FMT_TLV;
    end else if (cfg_i.valid) begin
      fmt_q <= cfg_i.record_format;
    end
  end

  // input register stage
  logic            s1_valid_q;
  tlvd_pkg::step_t s1_step_q;
  logic            advance;
  logic            has_result;
  tlvd_pkg::result_t result;

  // result register
  logic              out_valid_q;
  tlvd_pkg::result_t out_q;

  // the input stage moves on when its byte makes no result or the result slot frees
  assign advance = s1_valid_q && (!has_result || !out_valid_q || out_chan_o.ready);
  assign in_chan_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_chan_i.ready) begin
      s1_valid_q <= in_chan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan_i.ready && in_chan_i.valid) begin
      s1_step_q.frame_byte <= in_chan_i.frame_byte;
      s1_step_q.frame_last <= in_chan_i.frame_last;
    end
  end

  tlvd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_en_i       (advance),
    .step_i          (s1_step_q),
    .record_format_i (fmt_q),
    .has_result_o    (has_result),
    .result_o        (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_chan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      out_q <= result;
    end
  end

  assign out_chan_o.valid         = out_valid_q;
  assign out_chan_o.byte_kind     = out_q.byte_kind;
  assign out_chan_o.content_byte  = out_q.content_byte;
  assign out_chan_o.record_tag    = out_q.record_tag;
  assign out_chan_o.record_length = out_q.record_length;
  assign out_chan_o.record_end    = out_q.record_end;
  assign out_chan_o.status_word   = out_q.status_word;
  assign out_chan_o.error_code    = out_q.error_code;
  assign out_chan_o.frame_end     = out_q.frame_end;

endmodule

>>> hw/rtl/tlvd_parser.sv
// tlvd_parser: byte hold-back, tlv record parser state and per-byte result logic
// depends on tlvd_pkg

module tlvd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_en_i,
  input  tlvd_pkg::step_t  step_i,
  input  logic             record_format_i,
  output logic             has_result_o,
  output tlvd_pkg::result_t result_o
);

  typedef enum logic [1:0] {
    PH_TAG    = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_VALUE  = 2'd3
  } phase_e;

  logic [7:0]  held0_q, held0_d, held1_q, held1_d;
  logic [1:0]  cnt_q, cnt_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  tag_q, tag_d;
  logic [15:0] len_q, len_d;
  logic [15:0] rem_q, rem_d;

  // parse of the byte leaving the hold
  phase_e      p_phase;
  logic [7:0]  p_tag;
  logic [15:0] p_len, p_rem, p_rlen;
  logic [2:0]  p_kind;
  logic        p_end;

  always_comb begin
    p_phase = phase_q;
    p_tag   = tag_q;
    p_len   = len_q;
    p_rem   = rem_q;
    p_rlen  = '0;
    p_end   = 1'b0;
    p_kind  = tlvd_pkg::KIND_TAG;
    case (phase_q)
      PH_TAG: begin
        p_kind  = tlvd_pkg::KIND_TAG;
        p_tag   = held0_q;
        p_len   = '0;
        p_rem   = '0;
        p_phase = (record_format_i == tlvd_pkg::FMT_TLLV) ? PH_LEN_HI : PH_LEN_LO;
      end
      PH_LEN_HI: begin
        p_kind  = tlvd_pkg::KIND_LEN_HI;
        p_len   = {held0_q, 8'h00};
        p_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        p_kind = tlvd_pkg::KIND_LEN_LO;
        p_len  = {len_q[15:8], held0_q};
        p_rlen = p_len;
        if (p_len == 16'd0) begin
          p_end   = 1'b1;
          p_phase = PH_TAG;
        end else begin
          p_rem   = p_len;
          p_phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        p_kind = tlvd_pkg::KIND_VALUE;
        p_rlen = len_q;
        if (rem_q != 16'd0) p_rem = 16'(rem_q - 16'd1);
        if (p_rem == 16'd0) begin
          p_end   = 1'b1;
          p_phase = PH_TAG;
        end
      end
      default: begin
        p_phase = PH_TAG;
      end
    endcase
  end

  always_comb begin
    held0_d  = held0_q;
    held1_d  = held1_q;
    cnt_d    = cnt_q;
    phase_d  = phase_q;
    tag_d    = tag_q;
    len_d    = len_q;
    rem_d    = rem_q;
    has_result_o = 1'b0;
    result_o = '0;

    if (!step_i.frame_last && cnt_q != 2'd2) begin
      // filling the hold, nothing to report yet
      if (cnt_q == 2'd0) held0_d = step_i.frame_byte;
      else               held1_d = step_i.frame_byte;
      cnt_d = 2'(cnt_q + 2'd1);
    end else if (cnt_q == 2'd2) begin
      has_result_o           = 1'b1;
      result_o.byte_kind     = p_kind;
      result_o.content_byte  = held0_q;
      result_o.record_tag    = p_tag;
      result_o.record_length = p_rlen;
      result_o.record_end    = p_end;
      phase_d = p_phase;
      tag_d   = p_tag;
      len_d   = p_len;
      rem_d   = p_rem;
      held0_d = held1_q;
      held1_d = step_i.frame_byte;
      if (step_i.frame_last) begin
        result_o.frame_end   = 1'b1;
        result_o.status_word = {held1_q, step_i.frame_byte};
        case (p_phase)
          PH_LEN_HI, PH_LEN_LO: result_o.error_code = tlvd_pkg::ERR_HEADER;
          PH_VALUE:             result_o.error_code = tlvd_pkg::ERR_BOUNDS;
          default:              result_o.error_code = tlvd_pkg::ERR_NONE;
        endcase
      end
    end else begin
      // last byte with fewer than two held: no content
      has_result_o        = 1'b1;
      result_o.byte_kind  = tlvd_pkg::KIND_END;
      result_o.frame_end  = 1'b1;
      if (cnt_q == 2'd1) begin
        result_o.status_word = {held0_q, step_i.frame_byte};
        result_o.error_code  = tlvd_pkg::ERR_NONE;
      end else begin
        result_o.error_code  = tlvd_pkg::ERR_SHORT;
      end
    end

    if (step_i.frame_last) begin
      held0_d = '0;
      held1_d = '0;
      cnt_d   = '0;
      phase_d = PH_TAG;
      tag_d   = '0;
      len_d   = '0;
      rem_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held0_q <= '0;
      held1_q <= '0;
      cnt_q   <= '0;
      phase_q <= PH_TAG;
      tag_q   <= '0;
      len_q   <= '0;
      rem_q   <= '0;
    end else if (step_en_i) begin
      held0_q <= held0_d;
      held1_q <= held1_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
    end
  end

endmodule

>>> hw/rtl/tlvd_checker.sv
// tlvd_checker: port-level assertions on the result channel, bound to the top level
// depends on tlvd_pkg and the ports of tlv_response_deframer

module tlvd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  byte_kind,
  input logic [7:0]  content_byte,
  input logic [15:0] record_length,
  input logic        record_end,
  input logic [15:0] status_word,
  input logic [1:0]  error_code,
  input logic        frame_end
);

  // stalled result stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(byte_kind) && $stable(content_byte)
      && $stable(status_word) && $stable(error_code) && $stable(frame_end))
    else $error("result changed while stalled");

  // status and error only on the frame close
  a_status_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !frame_end |-> status_word == 16'd0 && error_code == tlvd_pkg::ERR_NONE)
    else $error("status or error outside frame end");

  // contentless result only closes a frame
  a_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && byte_kind == tlvd_pkg::KIND_END |->
      frame_end && content_byte == 8'd0 && record_length == 16'd0 && !record_end)
    else $error("bad frame-end result");

  // a record closes only on its length low or value byte
  a_record_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && record_end |->
      byte_kind == tlvd_pkg::KIND_LEN_LO || byte_kind == tlvd_pkg::KIND_VALUE)
    else $error("record end on header byte");

endmodule

bind tlv_response_deframer tlvd_checker u_tlvd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_chan_o.valid),
  .out_ready     (out_chan_o.ready),
  .byte_kind     (out_chan_o.byte_kind),
  .content_byte  (out_chan_o.content_byte),
  .record_length (out_chan_o.record_length),
  .record_end    (out_chan_o.record_end),
  .status_word   (out_chan_o.status_word),
  .error_code    (out_chan_o.error_code),
  .frame_end     (out_chan_o.frame_end)
);
